// ===== src/utc_pkg.sv =====
// utc_pkg: shared types and constants for the UTF-8 text canonicalizer.
// Used by utc_front, utc_queue, utc_back and utf8_text_canonicalizer.
// No dependencies.
package utc_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] MAX_SCALARS_RESET = 8'd128;
  localparam logic [2:0] ADDR_MAX_SCALARS  = 3'd0;
  localparam logic [7:0] SPACE_BYTE        = 8'h20;

  // Work for the back end from one input byte: an optional space, up to
  // four scalar bytes, an optional terminator.
  typedef struct packed {
    logic            space;
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            term;
    logic            bad;
  } action_t;

endpackage

// ===== src/utc_front.sv =====
// utc_front: UTF-8 decode, scalar classification, trim and limit tracking.
// Produces at most one utc_pkg::action_t per accepted byte. Depends on utc_pkg.
module utc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [7:0]        max_scalars,
  output utc_pkg::action_t  act,
  output logic              act_valid
);

  typedef enum logic [1:0] {
    KIND_TEXT,
    KIND_SPACE,
    KIND_DROP
  } kind_t;

  logic [23:0] scalar_bytes, scalar_bytes_next;
  logic [1:0]  bytes_left, bytes_left_next;
  logic        seen_text, seen_text_next;
  logic        pending_space, pending_space_next;
  logic [7:0]  scalar_count, scalar_count_next;
  logic        cut_off, cut_off_next;
  logic        utf8_error, utf8_error_next;

  logic [7:0]      lead;
  logic [2:0]      lead_len;
  logic [2:0]      k;
  logic            ok;
  logic            have_sc;
  logic [2:0]      sc_len;
  logic [3:0][7:0] sc_b;
  kind_t           kind;

  function automatic logic [2:0] seq_len(input logic [7:0] lb);
    logic [2:0] r;
    if (lb >= 8'hF0)      r = 3'd4;
    else if (lb >= 8'hE0) r = 3'd3;
    else                  r = 3'd2;
    return r;
  endfunction

  function automatic kind_t classify(input logic [2:0] len, input logic [3:0][7:0] b);
    kind_t r;
    r = KIND_TEXT;
    case (len)
      3'd1: begin
        if (b[0] == 8'h0D)       r = KIND_DROP;
        else if (b[0] <= 8'h20)  r = KIND_SPACE;
      end
      3'd2: begin
        if (b[0] == 8'hC2 && b[1] == 8'hA0) r = KIND_SPACE;
        else if (b[0] == 8'hCC && (b[1] inside {8'hB3, 8'hBF, 8'h8A})) r = KIND_DROP;
      end
      3'd3: begin
        if (b[0] == 8'hE2 && b[1] == 8'h80) begin
          if (b[2] >= 8'hA8 && b[2] <= 8'hAE)       r = KIND_DROP;
          else if (b[2] <= 8'h8A || b[2] == 8'hAF)  r = KIND_SPACE;
        end else if ((b[0] == 8'hE1 && b[1] == 8'h9A && b[2] == 8'h80) ||
                     (b[0] == 8'hE1 && b[1] == 8'hA0 && b[2] == 8'h8E) ||
                     (b[0] == 8'hE2 && b[1] == 8'h81 && b[2] == 8'h9F) ||
                     (b[0] == 8'hE2 && b[1] == 8'hA0 && b[2] == 8'h80) ||
                     (b[0] == 8'hE3 && b[1] == 8'h80 && b[2] == 8'h80) ||
                     (b[0] == 8'hEF && b[1] == 8'hBF && b[2] == 8'hBC)) begin
          r = KIND_SPACE;
        end
      end
      3'd4: begin
        if (b[0] == 8'hF3 && b[1] == 8'hA0 && b[2] == 8'h80 && b[3] == 8'h80) r = KIND_SPACE;
      end
      default: r = KIND_TEXT;
    endcase
    return r;
  endfunction

  always_comb begin
    scalar_bytes_next  = scalar_bytes;
    bytes_left_next    = bytes_left;
    seen_text_next     = seen_text;
    pending_space_next = pending_space;
    scalar_count_next  = scalar_count;
    cut_off_next       = cut_off;
    utf8_error_next    = utf8_error;
    act                = '0;
    have_sc            = 1'b0;
    sc_len             = 3'd1;
    sc_b               = '0;
    lead               = scalar_bytes[23:16];
    lead_len           = seq_len(lead);
    k                  = lead_len - {1'b0, bytes_left};
    ok                 = data_byte >= 8'h80 && data_byte <= 8'hBF;

    if (k == 3'd1) begin
      if (lead == 8'hE0 && data_byte < 8'hA0) ok = 1'b0;
      if (lead == 8'hED && data_byte > 8'h9F) ok = 1'b0;
      if (lead == 8'hF0 && data_byte < 8'h90) ok = 1'b0;
      if (lead == 8'hF4 && data_byte > 8'h8F) ok = 1'b0;
    end

    if (!utf8_error) begin
      if (bytes_left == 2'd0) begin
        if (data_byte <= 8'h7F) begin
          have_sc = 1'b1;
          sc_b[0] = data_byte;
        end else if (data_byte < 8'hC2 || data_byte > 8'hF4) begin
          utf8_error_next = 1'b1;
        end else begin
          scalar_bytes_next = {data_byte, 16'h0000};
          bytes_left_next   = 2'(seq_len(data_byte) - 3'd1);
        end
      end else if (!ok) begin
        utf8_error_next = 1'b1;
        bytes_left_next = 2'd0;
      end else begin
        bytes_left_next = bytes_left - 2'd1;
        if (bytes_left != 2'd1) begin
          if (k == 3'd1) scalar_bytes_next[15:8] = data_byte;
          else           scalar_bytes_next[7:0]  = data_byte;
        end else begin
          have_sc = 1'b1;
          sc_len  = lead_len;
          sc_b[0] = lead;
          sc_b[1] = scalar_bytes[15:8];
          sc_b[2] = scalar_bytes[7:0];
          case (lead_len)
            3'd2:    sc_b[1] = data_byte;
            3'd3:    sc_b[2] = data_byte;
            default: sc_b[3] = data_byte;
          endcase
        end
      end
    end

    kind = classify(sc_len, sc_b);

    if (have_sc && kind != KIND_DROP && !cut_off) begin
      if (kind == KIND_SPACE) begin
        if (seen_text) begin
          if (scalar_count == max_scalars) begin
            cut_off_next = 1'b1;
          end else begin
            scalar_count_next  = scalar_count + 8'd1;
            pending_space_next = 1'b1;
          end
        end
      end else if (scalar_count == max_scalars) begin
        cut_off_next = 1'b1;
      end else begin
        scalar_count_next  = scalar_count + 8'd1;
        act.space          = pending_space;
        act.nbytes         = sc_len;
        act.bytes          = sc_b;
        pending_space_next = 1'b0;
        seen_text_next     = 1'b1;
      end
    end

    if (last_byte) begin
      if (bytes_left_next != 2'd0) utf8_error_next = 1'b1;
      act.term           = 1'b1;
      act.bad            = utf8_error_next;
      scalar_bytes_next  = '0;
      bytes_left_next    = '0;
      seen_text_next     = 1'b0;
      pending_space_next = 1'b0;
      scalar_count_next  = '0;
      cut_off_next       = 1'b0;
      utf8_error_next    = 1'b0;
    end

    act_valid = act.space || act.nbytes != 3'd0 || act.term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scalar_bytes  <= '0;
      bytes_left    <= '0;
      seen_text     <= 1'b0;
      pending_space <= 1'b0;
      scalar_count  <= '0;
      cut_off       <= 1'b0;
      utf8_error    <= 1'b0;
    end else if (accept) begin
      scalar_bytes  <= scalar_bytes_next;
      bytes_left    <= bytes_left_next;
      seen_text     <= seen_text_next;
      pending_space <= pending_space_next;
      scalar_count  <= scalar_count_next;
      cut_off       <= cut_off_next;
      utf8_error    <= utf8_error_next;
    end
  end

  a_err_no_partial: assert property (@(posedge clk) disable iff (rst)
    utf8_error |-> bytes_left == 2'd0)
    else $error("partial scalar held after error");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> scalar_count == 8'd0 && !utf8_error && !seen_text)
    else $error("string state not cleared after final byte");

endmodule

// ===== src/utc_queue.sv =====
// utc_queue: small FIFO of utc_pkg::action_t between front and back ends.
// Depends on utc_pkg.
module utc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  utc_pkg::action_t  din,
  output logic              full,
  input  logic              pop,
  output utc_pkg::action_t  dout,
  output logic              nonempty
);

  utc_pkg::action_t             slots [utc_pkg::QDEPTH];
  logic [utc_pkg::QAW-1:0]      wptr, rptr;
  logic [utc_pkg::QCW-1:0]      count;

  assign full     = count == utc_pkg::QCW'(utc_pkg::QDEPTH);
  assign nonempty = count != '0;
  assign dout     = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from empty queue");

endmodule

// ===== src/utc_back.sv =====
// utc_back: walks the head action of the queue, one result per cycle unless
// res_ready stalls it, into a registered output stage. Depends on utc_pkg.
module utc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  utc_pkg::action_t  head,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              last,
  output logic              bad_utf8
);

  logic       sp_done, sp_done_next;
  logic       bytes_done, bytes_done_next;
  logic [1:0] bidx, bidx_next;
  logic       advance;
  logic       fin;
  logic       last_of_bytes;
  logic [7:0] nxt_byte;
  logic       nxt_bv;

  assign advance       = !res_valid || res_ready;
  assign last_of_bytes = {1'b0, bidx} == head.nbytes - 3'd1;

  always_comb begin
    sp_done_next    = sp_done;
    bytes_done_next = bytes_done;
    bidx_next       = bidx;
    fin             = 1'b0;
    nxt_byte        = 8'h00;
    nxt_bv          = 1'b0;
    if (head.space && !sp_done) begin
      nxt_byte     = utc_pkg::SPACE_BYTE;
      nxt_bv       = 1'b1;
      sp_done_next = 1'b1;
      fin          = head.nbytes == 3'd0 && !head.term;
    end else if (head.nbytes != 3'd0 && !bytes_done) begin
      nxt_byte = head.bytes[bidx];
      nxt_bv   = 1'b1;
      fin      = last_of_bytes && !head.term;
      if (last_of_bytes) bytes_done_next = 1'b1;
      else               bidx_next       = bidx + 2'd1;
    end else begin
      fin = 1'b1;
    end
    if (fin) begin
      sp_done_next    = 1'b0;
      bytes_done_next = 1'b0;
      bidx_next       = '0;
    end
  end

  assign pop = advance && head_valid && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      sp_done    <= 1'b0;
      bytes_done <= 1'b0;
      bidx       <= '0;
    end else if (advance) begin
      res_valid <= head_valid;
      if (head_valid) begin
        sp_done    <= sp_done_next;
        bytes_done <= bytes_done_next;
        bidx       <= bidx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      out_byte   <= nxt_byte;
      byte_valid <= nxt_bv;
      last       <= !nxt_bv;
      bad_utf8   <= !nxt_bv && head.bad;
    end
  end

  a_progress_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !sp_done && !bytes_done && bidx == 2'd0)
    else $error("progress held with empty queue");

endmodule

// ===== src/utf8_text_canonicalizer.sv =====
// utf8_text_canonicalizer: top level; APB register, front end, queue, back end.
// Depends on utc_pkg, utc_front, utc_queue, utc_back.
//
//   port group    dir  transfer condition           payload
//   src           in   src_valid && src_ready       data_byte, last_byte
//   res           out  res_valid && res_ready       out_byte, byte_valid, last, bad_utf8
//   apb           in   psel && penable && pwrite    paddr, pwdata (max_scalars at 0)
//
// One input byte per cycle while src_ready is high; each byte yields 0 to 6 results,
// sent one per cycle unless res_ready stalls, through the queue and output register.
// src_ready drops only when the 4-entry action queue is full.
// rst is synchronous; max_scalars resets to 128, all string state to zero.
module utf8_text_canonicalizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        src_valid,
  output logic        src_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic        bad_utf8
);

  logic [7:0]        max_scalars;
  logic              accept;
  logic              q_full;
  logic              q_nonempty;
  logic              q_pop;
  logic              act_valid;
  utc_pkg::action_t  act;
  utc_pkg::action_t  head;

  assign pready    = 1'b1;
  assign prdata    = (paddr == utc_pkg::ADDR_MAX_SCALARS) ? {24'h000000, max_scalars} : '0;
  assign src_ready = !q_full;
  assign accept    = src_valid && src_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_scalars <= utc_pkg::MAX_SCALARS_RESET;
    end else if (psel && penable && pwrite && paddr == utc_pkg::ADDR_MAX_SCALARS) begin
      max_scalars <= pwdata[7:0];
    end
  end

  utc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .max_scalars (max_scalars),
    .act         (act),
    .act_valid   (act_valid)
  );

  utc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && act_valid),
    .din      (act),
    .full     (q_full),
    .pop      (q_pop),
    .dout     (head),
    .nonempty (q_nonempty)
  );

  utc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_nonempty),
    .head       (head),
    .pop        (q_pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .bad_utf8   (bad_utf8)
  );

endmodule
